@@ rtl/dgd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dgd_pkg
// Shared types, codes and the CRC-8 byte update for the datagram deframer.
// ----------------------------------------------------------------------------
package dgd_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_START_MARKER = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CRC_POLY     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_EXP_ADDR     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_EXP_OPCODE   = 3'd4;

  localparam logic [7:0]  RST_START_MARKER = 8'd0;
  localparam logic [7:0]  RST_CRC_POLY     = 8'd140;
  localparam logic [15:0] RST_TIMEOUT      = 16'd1000;
  localparam logic [7:0]  RST_EXP_ADDR     = 8'd0;
  localparam logic [7:0]  RST_EXP_OPCODE   = 8'd0;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_STRAY  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_CRC     = 3'd1;
  localparam logic [2:0] ST_ADDR    = 3'd2;
  localparam logic [2:0] ST_OP      = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;
  localparam logic [2:0] ST_LEN     = 3'd5;

  localparam logic [7:0] MIN_LENGTH = 8'd4;
  localparam logic [15:0] GAP_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  crc_polynomial;
    logic [15:0] timeout_ticks;
    logic [7:0]  expected_address;
    logic [7:0]  expected_opcode;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [2:0] frame_status;
    logic [7:0] payload_count;
    logic       frame_end;
  } result_t;

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b,
                                            input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/dgd_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dgd_cfg
// Configuration register file, written through a valid/ready port.
// ----------------------------------------------------------------------------
module dgd_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dgd_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [dgd_pkg::CfgDataW-1:0]  cfg_data,
  output dgd_pkg::cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker     <= dgd_pkg::RST_START_MARKER;
      cfg.crc_polynomial   <= dgd_pkg::RST_CRC_POLY;
      cfg.timeout_ticks    <= dgd_pkg::RST_TIMEOUT;
      cfg.expected_address <= dgd_pkg::RST_EXP_ADDR;
      cfg.expected_opcode  <= dgd_pkg::RST_EXP_OPCODE;
    end else if (cfg_valid) begin
      case (cfg_index)
        dgd_pkg::CFG_START_MARKER: cfg.start_marker     <= cfg_data[7:0];
        dgd_pkg::CFG_CRC_POLY:     cfg.crc_polynomial   <= cfg_data[7:0];
        dgd_pkg::CFG_TIMEOUT:      cfg.timeout_ticks    <= cfg_data;
        dgd_pkg::CFG_EXP_ADDR:     cfg.expected_address <= cfg_data[7:0];
        dgd_pkg::CFG_EXP_OPCODE:   cfg.expected_opcode  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/dgd_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dgd_engine
// Input word register, frame state and the per-word deframing step.
// ----------------------------------------------------------------------------
module dgd_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              req_type,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              slot_free,
  input  wire dgd_pkg::cfg_t     cfg,
  output logic                   res_load,
  output dgd_pkg::result_t       res
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_ADDR = 3'd2;
  localparam logic [2:0] PH_OP   = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_CRC  = 3'd5;

  logic        q_valid;
  logic        tick_q;
  logic [7:0]  byte_q;
  logic        advance;

  logic [2:0]  phase, phase_next;
  logic [7:0]  crc_acc, crc_acc_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  body_index, body_index_next;
  logic        addr_match, addr_match_next;
  logic        op_match, op_match_next;
  logic [15:0] gap_counter, gap_counter_next;
  logic        emit;
  logic [7:0]  crc_step;
  logic [15:0] gap_inc;

  assign advance  = q_valid && slot_free;
  assign in_ready = !q_valid || advance;
  assign res_load = advance && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      tick_q <= req_type;
      byte_q <= rx_byte;
    end
  end

  assign crc_step = dgd_pkg::crc_update(crc_acc, byte_q, cfg.crc_polynomial);
  assign gap_inc  = (gap_counter != dgd_pkg::GAP_MAX) ? gap_counter + 16'd1 : gap_counter;

  always_comb begin
    phase_next       = phase;
    crc_acc_next     = crc_acc;
    bytes_left_next  = bytes_left;
    body_index_next  = body_index;
    addr_match_next  = addr_match;
    op_match_next    = op_match;
    gap_counter_next = gap_counter;
    emit             = 1'b0;
    res.kind          = dgd_pkg::KIND_STATUS;
    res.byte_value    = 8'd0;
    res.frame_status  = dgd_pkg::ST_OK;
    res.payload_count = body_index;
    res.frame_end     = 1'b1;
    if (tick_q) begin
      if (phase != PH_HUNT) begin
        gap_counter_next = gap_inc;
        if (gap_inc > cfg.timeout_ticks) begin
          emit             = 1'b1;
          res.frame_status = dgd_pkg::ST_TIMEOUT;
          phase_next       = PH_HUNT;
          gap_counter_next = 16'd0;
        end
      end
    end else begin
      gap_counter_next = 16'd0;
      case (phase)
        PH_LEN: begin
          crc_acc_next    = dgd_pkg::crc_update(8'd0, byte_q, cfg.crc_polynomial);
          body_index_next = 8'd0;
          res.payload_count = 8'd0;
          if (byte_q < dgd_pkg::MIN_LENGTH) begin
            emit             = 1'b1;
            res.frame_status = dgd_pkg::ST_LEN;
            phase_next       = PH_HUNT;
          end else begin
            bytes_left_next = byte_q - dgd_pkg::MIN_LENGTH;
            phase_next      = PH_ADDR;
          end
        end
        PH_ADDR: begin
          crc_acc_next    = crc_step;
          addr_match_next = (byte_q == cfg.expected_address);
          phase_next      = PH_OP;
        end
        PH_OP: begin
          crc_acc_next  = crc_step;
          op_match_next = (byte_q == cfg.expected_opcode);
          phase_next    = (bytes_left != 8'd0) ? PH_DATA : PH_CRC;
        end
        PH_DATA: begin
          crc_acc_next      = crc_step;
          body_index_next   = body_index + 8'd1;
          bytes_left_next   = bytes_left - 8'd1;
          if (bytes_left == 8'd1) begin
            phase_next = PH_CRC;
          end
          emit              = 1'b1;
          res.kind          = dgd_pkg::KIND_DATA;
          res.byte_value    = byte_q;
          res.payload_count = body_index + 8'd1;
          res.frame_end     = 1'b0;
        end
        PH_CRC: begin
          emit       = 1'b1;
          phase_next = PH_HUNT;
          if (byte_q != crc_acc) begin
            res.frame_status = dgd_pkg::ST_CRC;
          end else if (!addr_match) begin
            res.frame_status = dgd_pkg::ST_ADDR;
          end else if (!op_match) begin
            res.frame_status = dgd_pkg::ST_OP;
          end else begin
            res.frame_status = dgd_pkg::ST_OK;
          end
        end
        default: begin
          phase_next = PH_HUNT;
          if (byte_q == cfg.start_marker) begin
            phase_next      = PH_LEN;
            crc_acc_next    = 8'd0;
            body_index_next = 8'd0;
            bytes_left_next = 8'd0;
            addr_match_next = 1'b0;
            op_match_next   = 1'b0;
          end else begin
            emit              = 1'b1;
            res.kind          = dgd_pkg::KIND_STRAY;
            res.byte_value    = byte_q;
            res.payload_count = 8'd0;
            res.frame_end     = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      crc_acc     <= 8'd0;
      bytes_left  <= 8'd0;
      body_index  <= 8'd0;
      addr_match  <= 1'b0;
      op_match    <= 1'b0;
      gap_counter <= 16'd0;
    end else if (advance) begin
      phase       <= phase_next;
      crc_acc     <= crc_acc_next;
      bytes_left  <= bytes_left_next;
      body_index  <= body_index_next;
      addr_match  <= addr_match_next;
      op_match    <= op_match_next;
      gap_counter <= gap_counter_next;
    end
  end

  a_status_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (res_load && res.kind == dgd_pkg::KIND_STATUS) |=> (phase == PH_HUNT))
    else $error("status result did not return to hunting");

  a_hunt_gap_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT) |-> (gap_counter == 16'd0))
    else $error("gap counter running while hunting");

  a_frame_end_kind: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (res.frame_end == (res.kind == dgd_pkg::KIND_STATUS)))
    else $error("frame end flag disagrees with result kind");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !slot_free) |=> ($stable(phase) && $stable(crc_acc) && q_valid))
    else $error("state moved while stalled");

endmodule
`default_nettype wire

@@ rtl/dgd_out_reg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dgd_out_reg
// Result register holding one word until the downstream side takes it.
// ----------------------------------------------------------------------------
module dgd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire dgd_pkg::result_t  res,
  output logic                   slot_free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dgd_pkg::result_t       held
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule
`default_nettype wire

@@ rtl/datagram_deframer_crc8.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// datagram_deframer_crc8
// Serial frame receiver: start-byte hunt, reflected CRC-8 check, data and
// status words out.
//
//   channel  signals                                   direction
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data   in
//   in       in_valid/in_ready, req_type, rx_byte       in
//   out      out_valid/out_ready, kind, byte_value,     out
//            frame_status, payload_count, frame_end
//
// One word per cycle sustained while the result register drains; a result word
// goes from the input register through combinational step logic (CRC-8 byte
// update unrolled) into the result register.
// rst is synchronous; it clears frame state and loads register defaults.
// A stalled result register holds the step; in_ready stays high while the
// result register is empty or being drained. cfg_ready is always high.
// ----------------------------------------------------------------------------
module datagram_deframer_crc8 (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dgd_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [dgd_pkg::CfgDataW-1:0]  cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          req_type,
  input  wire logic [7:0]                    rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         kind,
  output logic [7:0]                         byte_value,
  output logic [2:0]                         frame_status,
  output logic [7:0]                         payload_count,
  output logic                               frame_end
);

  dgd_pkg::cfg_t    cfg;
  dgd_pkg::result_t res;
  dgd_pkg::result_t held;
  logic             res_load;
  logic             slot_free;

  dgd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dgd_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .rx_byte   (rx_byte),
    .slot_free (slot_free),
    .cfg       (cfg),
    .res_load  (res_load),
    .res       (res)
  );

  dgd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign kind          = held.kind;
  assign byte_value    = held.byte_value;
  assign frame_status  = held.frame_status;
  assign payload_count = held.payload_count;
  assign frame_end     = held.frame_end;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_status_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> (byte_value == 8'd0))
    else $error("status word carries a byte value");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    res_load |-> slot_free)
    else $error("result loaded over a pending word");

endmodule
`default_nettype wire

@@ tb/sv/dgd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgd_checker
// Watches the register, byte and result channels of the datagram deframer.
// Keeps its own copy of the registers and the frame state, works out the
// words each accepted byte or tick must produce, and compares every result
// word in order against them. Counts failures and hands the number of words
// still owed to the top.
// ----------------------------------------------------------------------------
module dgd_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [dgd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dgd_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          req_type,
  input  logic [7:0]                    rx_byte,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [1:0]                    kind,
  input  logic [7:0]                    byte_value,
  input  logic [2:0]                    frame_status,
  input  logic [7:0]                    payload_count,
  input  logic                          frame_end,
  output int                            pending,
  output int                            fail_count
);

  localparam logic [2:0] HUNT     = 3'd0;
  localparam logic [2:0] GET_LEN  = 3'd1;
  localparam logic [2:0] GET_ADDR = 3'd2;
  localparam logic [2:0] GET_OP   = 3'd3;
  localparam logic [2:0] GET_DATA = 3'd4;
  localparam logic [2:0] GET_CRC  = 3'd5;

  dgd_pkg::cfg_t    regs;
  logic [2:0]       phase;
  logic [7:0]       crc_acc;
  logic [7:0]       left;
  logic [7:0]       count;
  logic             addr_ok;
  logic             op_ok;
  logic [15:0]      gap;
  dgd_pkg::result_t owed_words[$];

  function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    return c;
  endfunction

  task automatic close_frame(input logic [2:0] st, output dgd_pkg::result_t w);
    w = {dgd_pkg::KIND_STATUS, 8'd0, st, count, 1'b1};
    phase = HUNT;
    gap = '0;
  endtask

  task automatic deframe_word(input logic is_tick, input logic [7:0] b,
                              output logic emit, output dgd_pkg::result_t w);
    emit = 1'b0;
    w = '0;
    if (is_tick) begin
      if (phase != HUNT) begin
        if (gap != dgd_pkg::GAP_MAX) gap = gap + 16'd1;
        if (gap > regs.timeout_ticks) begin
          close_frame(dgd_pkg::ST_TIMEOUT, w);
          emit = 1'b1;
        end
      end
    end else begin
      gap = '0;
      case (phase)
        GET_LEN: begin
          crc_acc = crc8_byte(8'd0, b, regs.crc_polynomial);
          count = '0;
          if (b < dgd_pkg::MIN_LENGTH) begin
            close_frame(dgd_pkg::ST_LEN, w);
            emit = 1'b1;
          end else begin
            left = b - dgd_pkg::MIN_LENGTH;
            phase = GET_ADDR;
          end
        end
        GET_ADDR: begin
          crc_acc = crc8_byte(crc_acc, b, regs.crc_polynomial);
          addr_ok = (b == regs.expected_address);
          phase = GET_OP;
        end
        GET_OP: begin
          crc_acc = crc8_byte(crc_acc, b, regs.crc_polynomial);
          op_ok = (b == regs.expected_opcode);
          phase = (left != 8'd0) ? GET_DATA : GET_CRC;
        end
        GET_DATA: begin
          crc_acc = crc8_byte(crc_acc, b, regs.crc_polynomial);
          count = count + 8'd1;
          left = left - 8'd1;
          if (left == 8'd0) phase = GET_CRC;
          w = {dgd_pkg::KIND_DATA, b, dgd_pkg::ST_OK, count, 1'b0};
          emit = 1'b1;
        end
        GET_CRC: begin
          emit = 1'b1;
          if (b != crc_acc) close_frame(dgd_pkg::ST_CRC, w);
          else if (!addr_ok) close_frame(dgd_pkg::ST_ADDR, w);
          else if (!op_ok) close_frame(dgd_pkg::ST_OP, w);
          else close_frame(dgd_pkg::ST_OK, w);
        end
        default: begin
          if (b == regs.start_marker) begin
            phase = GET_LEN;
            crc_acc = '0;
            count = '0;
            left = '0;
            addr_ok = 1'b0;
            op_ok = 1'b0;
          end else begin
            w = {dgd_pkg::KIND_STRAY, b, dgd_pkg::ST_OK, 8'd0, 1'b0};
            emit = 1'b1;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin : track
    dgd_pkg::result_t seen;
    dgd_pkg::result_t want;
    dgd_pkg::result_t made;
    logic             emit;
    if (rst) begin
      regs = {dgd_pkg::RST_START_MARKER, dgd_pkg::RST_CRC_POLY, dgd_pkg::RST_TIMEOUT,
              dgd_pkg::RST_EXP_ADDR, dgd_pkg::RST_EXP_OPCODE};
      phase = HUNT;
      crc_acc = '0;
      left = '0;
      count = '0;
      addr_ok = 1'b0;
      op_ok = 1'b0;
      gap = '0;
      owed_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dgd_pkg::CFG_START_MARKER: regs.start_marker = cfg_data[7:0];
          dgd_pkg::CFG_CRC_POLY:     regs.crc_polynomial = cfg_data[7:0];
          dgd_pkg::CFG_TIMEOUT:      regs.timeout_ticks = cfg_data;
          dgd_pkg::CFG_EXP_ADDR:     regs.expected_address = cfg_data[7:0];
          dgd_pkg::CFG_EXP_OPCODE:   regs.expected_opcode = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen = {kind, byte_value, frame_status, payload_count, frame_end};
        if (owed_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word kind=%0d value=%0d status=%0d count=%0d end=%0d",
                   $time, seen.kind, seen.byte_value, seen.frame_status,
                   seen.payload_count, seen.frame_end);
        end else begin
          want = owed_words.pop_front();
          if (seen !== want) begin
            fail_count++;
            $display("%0t: expected kind=%0d value=%0d status=%0d count=%0d end=%0d",
                     $time, want.kind, want.byte_value, want.frame_status,
                     want.payload_count, want.frame_end);
            $display("%0t: actual   kind=%0d value=%0d status=%0d count=%0d end=%0d",
                     $time, seen.kind, seen.byte_value, seen.frame_status,
                     seen.payload_count, seen.frame_end);
          end
        end
      end
      if (in_valid && in_ready) begin
        deframe_word(req_type, rx_byte, emit, made);
        if (emit) owed_words.insert(owed_words.size(), made);
      end
    end
    pending <= owed_words.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the datagram deframer. Sends directed frames
// (bad lengths, status precedence, zero timeout, longest frame), then
// mostly well-formed random frames with stray bytes and ticks mixed in,
// under several register settings and with random stalls on both sides.
// Ends with a long tick gap inside a frame under the widest timeout.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RX_HOLD = 400;
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;
  localparam logic [dgd_pkg::CfgIdxW-1:0] CFG_UNUSED = 3'd7;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [dgd_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [dgd_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         req_type = 1'b0;
  logic [7:0]                   rx_byte = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [1:0]                   kind;
  logic [7:0]                   byte_value;
  logic [2:0]                   frame_status;
  logic [7:0]                   payload_count;
  logic                         frame_end;
  int                           pending;
  int                           fail_count;

  logic          tx_idle_en = 1'b1;
  logic          rx_idle_en = 1'b1;
  logic          rx_hold_req = 1'b0;
  dgd_pkg::cfg_t live;
  int            sent = 0;
  int            quiet = 0;

  datagram_deframer_crc8 dut (.*);
  dgd_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : rx_side
    logic held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
      end
      out_ready <= !rx_idle_en || ($urandom_range(0, 99) >= 30);
    end
  end

  task automatic push_word(input logic tick, input logic [7:0] b, input bit counts);
    if (tx_idle_en && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= tick;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counts) sent++;
  endtask

  task automatic frame_byte(input logic [7:0] b, input int tick_pct);
    if ($urandom_range(0, 99) < tick_pct) begin
      repeat ($urandom_range(0, (live.timeout_ticks > 16'd6) ? 2 : int'(live.timeout_ticks) + 1))
        push_word(REQ_TICK, 8'($urandom), 1'b1);
    end
    push_word(REQ_BYTE, b, 1'b1);
  endtask

  task automatic send_frame(input logic [7:0] len, input logic [7:0] addr, input logic [7:0] op,
                            input logic bad_crc, input int tick_pct, input int pre_crc_ticks);
    logic [7:0] acc;
    logic [7:0] d;
    push_word(REQ_BYTE, live.start_marker, 1'b1);
    frame_byte(len, tick_pct);
    acc = dgd_pkg::crc_update(8'd0, len, live.crc_polynomial);
    if (len >= dgd_pkg::MIN_LENGTH) begin
      frame_byte(addr, tick_pct);
      acc = dgd_pkg::crc_update(acc, addr, live.crc_polynomial);
      frame_byte(op, tick_pct);
      acc = dgd_pkg::crc_update(acc, op, live.crc_polynomial);
      repeat (len - dgd_pkg::MIN_LENGTH) begin
        d = ($urandom_range(0, 9) == 0) ? live.start_marker : 8'($urandom);
        frame_byte(d, tick_pct);
        acc = dgd_pkg::crc_update(acc, d, live.crc_polynomial);
      end
      repeat (pre_crc_ticks) push_word(REQ_TICK, 8'($urandom), 1'b0);
      frame_byte(bad_crc ? acc ^ 8'($urandom_range(1, 255)) : acc, tick_pct);
    end
  endtask

  task automatic random_traffic(input int n);
    int         goal;
    int         r;
    int         k;
    logic [7:0] len;
    logic [7:0] addr;
    logic [7:0] op;
    goal = sent + n;
    while (sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) push_word(REQ_BYTE, 8'($urandom), 1'b1);
      end else if (r < 12) begin
        repeat ($urandom_range(1, 3)) push_word(REQ_TICK, 8'($urandom), 1'b0);
      end else begin
        k = $urandom_range(0, 99);
        if (k < 2) len = 8'($urandom_range(4, 255));
        else if (k < 10) len = 8'($urandom_range(0, 3));
        else len = 8'($urandom_range(4, 12));
        addr = ($urandom_range(0, 99) < 85) ? live.expected_address : 8'($urandom);
        op = ($urandom_range(0, 99) < 85) ? live.expected_opcode : 8'($urandom);
        send_frame(len, addr, op, $urandom_range(0, 99) < 10, 10, 0);
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dgd_pkg::CfgIdxW-1:0] idx,
                           input logic [dgd_pkg::CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] start, input logic [7:0] poly,
                           input logic [15:0] tmo, input logic [7:0] addr,
                           input logic [7:0] op);
    write_reg(dgd_pkg::CFG_START_MARKER, {8'($urandom), start});
    write_reg(dgd_pkg::CFG_CRC_POLY, {8'($urandom), poly});
    write_reg(dgd_pkg::CFG_TIMEOUT, tmo);
    write_reg(dgd_pkg::CFG_EXP_ADDR, {8'($urandom), addr});
    write_reg(dgd_pkg::CFG_EXP_OPCODE, {8'($urandom), op});
    write_reg(CFG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
    live.start_marker = start;
    live.crc_polynomial = poly;
    live.timeout_ticks = tmo;
    live.expected_address = addr;
    live.expected_opcode = op;
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    live = {dgd_pkg::RST_START_MARKER, dgd_pkg::RST_CRC_POLY, dgd_pkg::RST_TIMEOUT,
            dgd_pkg::RST_EXP_ADDR, dgd_pkg::RST_EXP_OPCODE};
    @(posedge clk);

    push_word(REQ_BYTE, 8'hFF, 1'b1);
    push_word(REQ_TICK, 8'h00, 1'b0);
    push_word(REQ_BYTE, live.start_marker, 1'b1);
    push_word(REQ_BYTE, 8'd0, 1'b1);
    push_word(REQ_BYTE, live.start_marker, 1'b1);
    push_word(REQ_BYTE, 8'd3, 1'b1);
    send_frame(8'd4, 8'h00, 8'h00, 1'b0, 0, 0);
    send_frame(8'd5, 8'h01, 8'hFF, 1'b1, 0, 0);
    send_frame(8'd4, 8'h01, 8'hFF, 1'b0, 0, 0);
    send_frame(8'd4, 8'h00, 8'hFF, 1'b0, 0, 0);
    settle();

    configure(8'hFF, 8'h00, 16'd0, 8'hFF, 8'hFF);
    push_word(REQ_BYTE, 8'hFF, 1'b1);
    push_word(REQ_TICK, 8'($urandom), 1'b1);
    send_frame(8'hFF, 8'hFF, 8'hFF, 1'b0, 0, 0);
    random_traffic(200);
    settle();

    configure(8'hA5, 8'h8C, 16'd3, 8'h12, 8'h34);
    random_traffic(80);
    rx_hold_req <= 1'b1;
    random_traffic(150);
    settle();

    tx_idle_en <= 1'b0;
    rx_idle_en <= 1'b0;
    configure(8'h00, 8'hFF, 16'd1, 8'h00, 8'h00);
    random_traffic(200);
    settle();

    tx_idle_en <= 1'b1;
    rx_idle_en <= 1'b1;
    configure(8'($urandom), 8'($urandom), 16'($urandom_range(1, 6)), 8'($urandom),
              8'($urandom));
    random_traffic(200);
    settle();

    tx_idle_en <= 1'b0;
    rx_idle_en <= 1'b0;
    configure(8'h3C, 8'($urandom), 16'hFFFF, 8'h5A, 8'hC3);
    send_frame(8'd4, 8'h5A, 8'hC3, 1'b0, 0, 40);
    settle();

    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/dgd_pkg.sv
rtl/dgd_cfg.sv
rtl/dgd_engine.sv
rtl/dgd_out_reg.sv
rtl/datagram_deframer_crc8.sv
tb/sv/dgd_checker.sv
tb/sv/tb.sv
